### hw/rtl/ptg_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package ptg_pkg;

  localparam int MAX_DIM   = 4096;
  localparam int FRAC_BITS = 16;

  // quotient of h*N/den lands in Q56+Q16-Q32 = Q40, drop down to FRAC_BITS
  localparam int SHIFT  = 40 - FRAC_BITS;
  localparam int XM_W   = 62;
  localparam int A_W    = 44;
  localparam int DEN_W  = 45;
  localparam int P_W    = 76;
  localparam int N_W    = 77;
  localparam int NH_W   = 108;
  localparam int DD_W   = DEN_W + SHIFT;
  localparam int TOP_W  = NH_W - XM_W;
  localparam int MS_L   = (FRAC_BITS >= 16) ? FRAC_BITS - 16 : 0;
  localparam int MS_R   = (FRAC_BITS < 16) ? 16 - FRAC_BITS : 0;

  localparam logic [XM_W-1:0] LIM62 = {XM_W{1'b1}};

  localparam int CFG_IDX_W = 3;
  localparam int CFG_DW    = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_ROWS       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_COLS       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TILT_TANGENT     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_OVER_FOCAL = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MOUNT_HEIGHT     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_MAST_OFFSET      = 3'd5;

  typedef struct packed {
    logic [11:0] pixel_row;
    logic [11:0] pixel_col;
  } ptg_in_t;

  typedef struct packed {
    logic signed [31:0] ground_x;
    logic signed [31:0] ground_y;
    logic               not_on_ground;
  } ptg_out_t;

  typedef struct packed {
    logic [12:0]        image_rows;
    logic [12:0]        image_cols;
    logic signed [31:0] tilt_tangent;
    logic [31:0]        pixel_over_focal;
    logic [30:0]        mount_height;
    logic signed [31:0] mast_offset;
  } ptg_cfg_t;

  typedef struct packed {
    logic [A_W-1:0] b;
    logic           nneg;
    logic           ong;
    logic           cneg;
    logic           czero;
  } ptg_side_t;

  function automatic logic [11:0] half_of(input logic [12:0] size);
    logic [16:0] s;
    logic [16:0] h;
    s = ({4'd0, size} > 17'(MAX_DIM)) ? 17'(MAX_DIM) : {4'd0, size};
    h = (s != 17'd0) ? ((s - 17'd1) >> 1) : 17'd0;
    return h[11:0];
  endfunction

  function automatic logic [31:0] sat32(input logic signed [63:0] v);
    logic [31:0] r;
    if (v > 64'sd2147483647) begin
      r = 32'h7FFF_FFFF;
    end else if (v < -64'sd2147483648) begin
      r = 32'h8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

### hw/rtl/ptg_front.sv
`timescale 1ns / 1ps
`default_nettype none
module ptg_front import ptg_pkg::*; (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            en,
  input  wire logic            in_v,
  input  wire ptg_in_t         in_data,
  input  wire ptg_cfg_t        cfg,
  output logic                 out_v,
  output logic [NH_W-1:0]      out_n,
  output logic [DEN_W-1:0]     out_den,
  output ptg_side_t            out_side
);

  // stage 1: centring
  logic              v1_r;
  logic [11:0]       ar_r, ac_r;
  logic              rneg_r, cneg1_r, czero1_r;
  logic signed [12:0] rc_nxt, cc_nxt, arc_nxt, acc_nxt;

  always_comb begin
    rc_nxt  = $signed({1'b0, in_data.pixel_row}) - $signed({1'b0, half_of(cfg.image_rows)});
    cc_nxt  = $signed({1'b0, in_data.pixel_col}) - $signed({1'b0, half_of(cfg.image_cols)});
    arc_nxt = rc_nxt[12] ? -rc_nxt : rc_nxt;
    acc_nxt = cc_nxt[12] ? -cc_nxt : cc_nxt;
  end

  // stage 2: scale by pixel over focal
  logic           v2_r;
  logic [A_W-1:0] a2_r, b2_r;
  logic           rneg2_r, cneg2_r, czero2_r;

  // stage 3: denominator and partial products of T*a
  logic              v3_r;
  logic signed [45:0] den3_r;
  logic [53:0]       pa0_r, pa1_r;
  logic [A_W-1:0]    b3_r;
  logic              tneg3_r, rneg3_r, cneg3_r, czero3_r;
  logic signed [45:0] tb_nxt, sa_nxt;
  logic [31:0]       tmag_nxt;

  always_comb begin
    tb_nxt   = {{6{cfg.tilt_tangent[31]}}, cfg.tilt_tangent, 8'd0};
    sa_nxt   = rneg2_r ? -$signed({2'b00, a2_r}) : $signed({2'b00, a2_r});
    tmag_nxt = cfg.tilt_tangent[31] ? 32'(-cfg.tilt_tangent) : cfg.tilt_tangent;
  end

  // stage 4: T*a assembled, horizon test
  logic           v4_r;
  logic [P_W-1:0] p4_r;
  logic [DEN_W-1:0] den4_r;
  logic           ong4_r;
  logic [A_W-1:0] b4_r;
  logic           tneg4_r, rneg4_r, cneg4_r, czero4_r;

  // stage 5: 1 - T*a
  logic           v5_r;
  logic [N_W-1:0] n5_r;
  logic           nneg5_r;
  logic [DEN_W-1:0] den5_r;
  logic           ong5_r;
  logic [A_W-1:0] b5_r;
  logic           cneg5_r, czero5_r;
  logic [N_W-1:0] one_c, pw_c, n5_nxt;
  logic           nneg5_nxt;

  always_comb begin
    one_c = N_W'(1) << 56;
    pw_c  = {1'b0, p4_r};
    if (tneg4_r != rneg4_r) begin
      n5_nxt    = pw_c + one_c;
      nneg5_nxt = 1'b0;
    end else if (pw_c <= one_c) begin
      n5_nxt    = one_c - pw_c;
      nneg5_nxt = 1'b0;
    end else begin
      n5_nxt    = pw_c - one_c;
      nneg5_nxt = 1'b1;
    end
  end

  // stage 6: partial products of N*h
  logic           v6_r;
  logic [56:0]    q0_r, q1_r, q2_r;
  ptg_side_t      side6_r;
  logic [DEN_W-1:0] den6_r;

  // stage 7: N*h assembled
  logic           v7_r;
  logic [NH_W-1:0] n7_r;
  ptg_side_t      side7_r;
  logic [DEN_W-1:0] den7_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
      v7_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_v;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
      v6_r <= v5_r;
      v7_r <= v6_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ar_r      <= arc_nxt[11:0];
      ac_r      <= acc_nxt[11:0];
      rneg_r    <= rc_nxt[12];
      cneg1_r   <= cc_nxt[12];
      czero1_r  <= (cc_nxt == 13'sd0);

      a2_r      <= {12'd0, cfg.pixel_over_focal} * {32'd0, ar_r};
      b2_r      <= {12'd0, cfg.pixel_over_focal} * {32'd0, ac_r};
      rneg2_r   <= rneg_r;
      cneg2_r   <= cneg1_r;
      czero2_r  <= czero1_r;

      den3_r    <= tb_nxt + sa_nxt;
      pa0_r     <= {22'd0, tmag_nxt} * {32'd0, a2_r[21:0]};
      pa1_r     <= {22'd0, tmag_nxt} * {32'd0, a2_r[43:22]};
      b3_r      <= b2_r;
      tneg3_r   <= cfg.tilt_tangent[31];
      rneg3_r   <= rneg2_r;
      cneg3_r   <= cneg2_r;
      czero3_r  <= czero2_r;

      p4_r      <= {22'd0, pa0_r} + {pa1_r, 22'd0};
      den4_r    <= den3_r[DEN_W-1:0];
      ong4_r    <= den3_r[45] || (den3_r == 46'sd0);
      b4_r      <= b3_r;
      tneg4_r   <= tneg3_r;
      rneg4_r   <= rneg3_r;
      cneg4_r   <= cneg3_r;
      czero4_r  <= czero3_r;

      n5_r      <= n5_nxt;
      nneg5_r   <= nneg5_nxt;
      den5_r    <= den4_r;
      ong5_r    <= ong4_r;
      b5_r      <= b4_r;
      cneg5_r   <= cneg4_r;
      czero5_r  <= czero4_r;

      q0_r      <= {31'd0, n5_r[25:0]} * {26'd0, cfg.mount_height};
      q1_r      <= {31'd0, n5_r[51:26]} * {26'd0, cfg.mount_height};
      q2_r      <= {32'd0, n5_r[76:52]} * {26'd0, cfg.mount_height};
      side6_r.b     <= b5_r;
      side6_r.nneg  <= nneg5_r;
      side6_r.ong   <= ong5_r;
      side6_r.cneg  <= cneg5_r;
      side6_r.czero <= czero5_r;
      den6_r    <= den5_r;

      n7_r      <= {51'd0, q0_r} + {25'd0, q1_r, 26'd0} + {q2_r[55:0], 52'd0};
      side7_r   <= side6_r;
      den7_r    <= den6_r;
    end
  end

  assign out_v    = v7_r;
  assign out_n    = n7_r;
  assign out_den  = den7_r;
  assign out_side = side7_r;

endmodule
`default_nettype wire

### hw/rtl/ptg_div.sv
`timescale 1ns / 1ps
`default_nettype none
module ptg_div import ptg_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             en,
  input  wire logic             in_v,
  input  wire logic [NH_W-1:0]  in_n,
  input  wire logic [DEN_W-1:0] in_den,
  input  wire ptg_side_t        in_side,
  output logic                  out_v,
  output logic [XM_W-1:0]       out_q,
  output logic                  out_ovf,
  output ptg_side_t             out_side
);

  logic [DD_W-1:0] r_r   [0:XM_W];
  logic [XM_W-1:0] nlo_r [0:XM_W];
  logic [XM_W-1:0] q_r   [0:XM_W];
  logic [DD_W-1:0] dd_r  [0:XM_W];
  ptg_side_t       side_r[0:XM_W];
  logic [XM_W:0]   ovf_r;
  logic [XM_W:0]   v_r;

  logic [DD_W-1:0] dd_in, top_in;

  always_comb begin
    dd_in  = {in_den, SHIFT'(0)};
    top_in = DD_W'(in_n[NH_W-1:XM_W]);
  end

  // one restoring step per stage
  logic [DD_W:0]   t_c [0:XM_W-1];
  logic [DD_W:0]   s_c [0:XM_W-1];
  logic [XM_W-1:0] ge_c;

  always_comb begin
    for (int i = 0; i < XM_W; i++) begin
      t_c[i]  = {r_r[i], nlo_r[i][XM_W-1]};
      ge_c[i] = (t_c[i] >= {1'b0, dd_r[i]});
      s_c[i]  = ge_c[i] ? (t_c[i] - {1'b0, dd_r[i]}) : t_c[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[XM_W-1:0], in_v};
    end
  end

  // entry stage: quotient overflow test, then start remainder at the top bits
  always_ff @(posedge clk) begin
    if (en) begin
      ovf_r     <= {ovf_r[XM_W-1:0], (top_in >= dd_in)};
      r_r[0]    <= top_in;
      nlo_r[0]  <= in_n[XM_W-1:0];
      q_r[0]    <= '0;
      dd_r[0]   <= dd_in;
      side_r[0] <= in_side;
      for (int i = 0; i < XM_W; i++) begin
        r_r[i+1]    <= s_c[i][DD_W-1:0];
        nlo_r[i+1]  <= {nlo_r[i][XM_W-2:0], 1'b0};
        q_r[i+1]    <= {q_r[i][XM_W-2:0], ge_c[i]};
        dd_r[i+1]   <= dd_r[i];
        side_r[i+1] <= side_r[i];
      end
    end
  end

  assign out_v    = v_r[XM_W];
  assign out_q    = q_r[XM_W];
  assign out_ovf  = ovf_r[XM_W];
  assign out_side = side_r[XM_W];

endmodule
`default_nettype wire

### hw/rtl/ptg_back.sv
`timescale 1ns / 1ps
`default_nettype none
module ptg_back import ptg_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             en,
  input  wire logic             in_v,
  input  wire logic [XM_W-1:0]  in_q,
  input  wire logic             in_ovf,
  input  wire ptg_side_t        in_side,
  input  wire logic signed [31:0] mast_offset,
  output logic                  out_v,
  output ptg_out_t              out_data
);

  // stage 1: clamp x and split x*b
  logic            v1_r;
  logic [XM_W-1:0] xm1_r;
  logic [52:0]     ll_r, lh_r, hl_r, hh_r;
  ptg_side_t       side1_r;
  logic [XM_W-1:0] xm_c;

  assign xm_c = in_ovf ? LIM62 : in_q;

  // stage 2: pair sums
  logic            v2_r;
  logic [XM_W-1:0] xm2_r;
  logic [74:0]     sa_r, sb_r;
  ptg_side_t       side2_r;

  // stage 3: full product, shift and clamp
  logic            v3_r;
  logic [XM_W-1:0] xm3_r, ym3_r;
  ptg_side_t       side3_r;
  logic [105:0]    prod_c;
  logic [73:0]     sh_c;

  always_comb begin
    prod_c = {31'd0, sa_r} + {sb_r, 31'd0};
    sh_c   = prod_c[105:32];
  end

  // stage 4: signs, mast offset, saturation
  logic            v4_r;
  ptg_out_t        res4_r, res_c;
  logic signed [63:0] x_c, y_c, mf_c, mb_c;

  always_comb begin
    x_c  = side3_r.nneg ? -$signed({2'b00, xm3_r}) : $signed({2'b00, xm3_r});
    y_c  = (side3_r.nneg != side3_r.cneg) ? -$signed({2'b00, ym3_r})
                                          : $signed({2'b00, ym3_r});
    // truncate toward zero when rescaling down
    mb_c = (mast_offset[31] && (MS_R != 0)) ? ((64'sd1 <<< MS_R) - 64'sd1) : 64'sd0;
    mf_c = ((64'(mast_offset) <<< MS_L) + mb_c) >>> MS_R;
    if (side3_r.ong) begin
      res_c.ground_x      = 32'h7FFF_FFFF;
      res_c.ground_y      = side3_r.czero ? 32'h0000_0000 :
                            (side3_r.cneg ? 32'h8000_0000 : 32'h7FFF_FFFF);
      res_c.not_on_ground = 1'b1;
    end else begin
      res_c.ground_x      = sat32(x_c - mf_c);
      res_c.ground_y      = sat32(y_c);
      res_c.not_on_ground = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_v;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      xm1_r   <= xm_c;
      ll_r    <= {22'd0, xm_c[30:0]}  * {31'd0, in_side.b[21:0]};
      lh_r    <= {22'd0, xm_c[30:0]}  * {31'd0, in_side.b[43:22]};
      hl_r    <= {22'd0, xm_c[61:31]} * {31'd0, in_side.b[21:0]};
      hh_r    <= {22'd0, xm_c[61:31]} * {31'd0, in_side.b[43:22]};
      side1_r <= in_side;

      xm2_r   <= xm1_r;
      sa_r    <= {22'd0, ll_r} + {lh_r, 22'd0};
      sb_r    <= {22'd0, hl_r} + {hh_r, 22'd0};
      side2_r <= side1_r;

      xm3_r   <= xm2_r;
      ym3_r   <= (sh_c > 74'(LIM62)) ? LIM62 : sh_c[XM_W-1:0];
      side3_r <= side2_r;

      res4_r  <= res_c;
    end
  end

  assign out_v    = v4_r;
  assign out_data = res4_r;

endmodule
`default_nettype wire

### hw/rtl/pixel_to_ground_projection.sv
`timescale 1ns / 1ps
`default_nettype none
// 75 register stages: 7 front, 1 divider entry plus 62 quotient bits, 4 back, output register
// throughput: one word per cycle while the skid entry is empty; an output register plus one
// skid entry keeps the input open while one result waits
// reset: synchronous active-low rst_n clears all valids and loads register defaults
module pixel_to_ground_projection import ptg_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire ptg_in_t              in_data,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output ptg_out_t                  out_data,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_DW-1:0]    cfg_data
);

  ptg_cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.image_rows       <= 13'd480;
      cfg_r.image_cols       <= 13'd640;
      cfg_r.tilt_tangent     <= '0;
      cfg_r.pixel_over_focal <= '0;
      cfg_r.mount_height     <= '0;
      cfg_r.mast_offset      <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_IMAGE_ROWS:       cfg_r.image_rows       <= cfg_data[12:0];
        CFG_IMAGE_COLS:       cfg_r.image_cols       <= cfg_data[12:0];
        CFG_TILT_TANGENT:     cfg_r.tilt_tangent     <= cfg_data;
        CFG_PIXEL_OVER_FOCAL: cfg_r.pixel_over_focal <= cfg_data;
        CFG_MOUNT_HEIGHT:     cfg_r.mount_height     <= cfg_data[30:0];
        CFG_MAST_OFFSET:      cfg_r.mast_offset      <= cfg_data;
        default: ;
      endcase
    end
  end

  // whole pipeline moves together while the skid slot is free
  logic en;
  logic skid_v_r, out_v_r;
  ptg_out_t skid_r, out_r;

  assign en       = !skid_v_r;
  assign in_ready = en;

  logic             f_v;
  logic [NH_W-1:0]  f_n;
  logic [DEN_W-1:0] f_den;
  ptg_side_t        f_side;

  ptg_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_v     (in_valid),
    .in_data  (in_data),
    .cfg      (cfg_r),
    .out_v    (f_v),
    .out_n    (f_n),
    .out_den  (f_den),
    .out_side (f_side)
  );

  logic            d_v;
  logic [XM_W-1:0] d_q;
  logic            d_ovf;
  ptg_side_t       d_side;

  ptg_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_v     (f_v),
    .in_n     (f_n),
    .in_den   (f_den),
    .in_side  (f_side),
    .out_v    (d_v),
    .out_q    (d_q),
    .out_ovf  (d_ovf),
    .out_side (d_side)
  );

  logic     b_v;
  ptg_out_t b_data;

  ptg_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .en          (en),
    .in_v        (d_v),
    .in_q        (d_q),
    .in_ovf      (d_ovf),
    .in_side     (d_side),
    .mast_offset (cfg_r.mast_offset),
    .out_v       (b_v),
    .out_data    (b_data)
  );

  logic incoming;
  assign incoming = en && b_v;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (!out_v_r || out_ready) begin
      out_v_r  <= skid_v_r || incoming;
      skid_v_r <= 1'b0;
    end else if (incoming) begin
      skid_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_v_r || out_ready) begin
      out_r <= skid_v_r ? skid_r : b_data;
    end else if (incoming) begin
      skid_r <= b_data;
    end
  end

  assign out_valid = out_v_r;
  assign out_data  = out_r;

endmodule
`default_nettype wire

### dv/pixel_to_ground_projection_tb.sv
`timescale 1ns / 1ps
module pixel_to_ground_projection_tb;
  import ptg_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES   = 100;
  localparam int PHASE_ITEMS    = 115;
  localparam int RANDOM_PHASES  = 10;

  class ground_scoreboard;
    ptg_cfg_t cfg;
    ptg_out_t pending[$];

    function new();
      cfg.image_rows       = 13'd480;
      cfg.image_cols       = 13'd640;
      cfg.tilt_tangent     = '0;
      cfg.pixel_over_focal = '0;
      cfg.mount_height     = '0;
      cfg.mast_offset      = '0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] v);
      case (idx)
        CFG_IMAGE_ROWS:       cfg.image_rows       = v[12:0];
        CFG_IMAGE_COLS:       cfg.image_cols       = v[12:0];
        CFG_TILT_TANGENT:     cfg.tilt_tangent     = v;
        CFG_PIXEL_OVER_FOCAL: cfg.pixel_over_focal = v;
        CFG_MOUNT_HEIGHT:     cfg.mount_height     = v[30:0];
        CFG_MAST_OFFSET:      cfg.mast_offset      = v;
        default: ;
      endcase
    endfunction

    function logic [15:0] center_offset(logic [12:0] size);
      logic [15:0] s;
      s = (size > 13'd4096) ? 16'd4096 : 16'(size);
      return (s != 0) ? (s - 16'd1) / 16'd2 : 16'd0;
    endfunction

    function logic [31:0] clip32(logic signed [63:0] v);
      if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
      if (v < -64'sd2147483648) return 32'h8000_0000;
      return v[31:0];
    endfunction

    function ptg_out_t project(ptg_in_t px);
      logic signed [15:0] rc, cc;
      logic [15:0] ar, ac;
      logic [63:0] a, b, tmag;
      logic signed [63:0] t, den, x, mf;
      logic [127:0] p, n, q, xm, ym, one, lim;
      bit nneg, yneg;
      ptg_out_t r;
      rc = 16'(px.pixel_row) - center_offset(cfg.image_rows);
      cc = 16'(px.pixel_col) - center_offset(cfg.image_cols);
      ar = (rc < 0) ? -rc : rc;
      ac = (cc < 0) ? -cc : cc;
      a = 64'(cfg.pixel_over_focal) * 64'(ar);
      b = 64'(cfg.pixel_over_focal) * 64'(ac);
      t = cfg.tilt_tangent;
      den = t * 256 + ((rc < 0) ? -$signed(a) : $signed(a));
      if (den <= 0) begin
        // ray at or above the horizon
        r.ground_x = 32'h7FFF_FFFF;
        r.ground_y = (cc > 0) ? 32'h7FFF_FFFF : ((cc < 0) ? 32'h8000_0000 : 32'h0);
        r.not_on_ground = 1'b1;
        return r;
      end
      tmag = (t < 0) ? -t : t;
      one = 128'(1) << 56;
      lim = (128'(1) << 62) - 128'(1);
      p = 128'(tmag) * 128'(a);
      nneg = 0;
      if ((t < 0) != (rc < 0)) n = one + p;
      else if (p <= one) n = one - p;
      else begin
        nneg = 1;
        n = p - one;
      end
      q = (n * 128'(cfg.mount_height)) / 128'(den);
      xm = q >> (40 - FRAC_BITS);
      if (xm > lim) xm = lim;
      x = nneg ? -$signed(64'(xm)) : $signed(64'(xm));
      mf = cfg.mast_offset;
      ym = (xm * 128'(b)) >> 32;
      if (ym > lim) ym = lim;
      yneg = nneg != (cc < 0);
      r.ground_x = clip32(x - mf);
      r.ground_y = clip32(yneg ? -$signed(64'(ym)) : $signed(64'(ym)));
      r.not_on_ground = 1'b0;
      return r;
    endfunction

    function void note(ptg_in_t px);
      pending = {pending, project(px)};
    endfunction

    function string check(ptg_out_t got);
      ptg_out_t e;
      if (pending.size() == 0) return $sformatf("unexpected word %h", got);
      e = pending.pop_front();
      if (got.ground_x !== e.ground_x)
        return $sformatf("ground_x got %h want %h", got.ground_x, e.ground_x);
      if (got.ground_y !== e.ground_y)
        return $sformatf("ground_y got %h want %h", got.ground_y, e.ground_y);
      if (got.not_on_ground !== e.not_on_ground)
        return $sformatf("not_on_ground got %b want %b", got.not_on_ground, e.not_on_ground);
      return "";
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_ready;
  ptg_in_t in_data = '0;
  logic out_valid;
  logic out_ready = 0;
  ptg_out_t out_data;
  logic cfg_we = 0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DW-1:0] cfg_data = '0;

  ground_scoreboard sb = new();
  int errors = 0;
  int idle_cycles = 0;
  int burst_left = 0;
  int cycle = 0;
  int stall_left = 0;

  pixel_to_ground_projection dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  task automatic report(string msg);
    $display("mismatch at %0t: %s", $time, msg);
    errors++;
  endtask

  // receiver: rotates through four ready modes (always, random, occasional stalls, mostly ready)
  always @(posedge clk) begin
    cycle <= cycle + 1;
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready <= 1'b0;
    end else begin
      case ((cycle / 300) % 4)
        0: out_ready <= 1'b1;
        1: out_ready <= ($urandom_range(0, 1) == 1);
        2: begin
          if ($urandom_range(0, 15) == 0) begin
            stall_left <= $urandom_range(1, 30);
            out_ready <= 1'b0;
          end else begin
            out_ready <= 1'b1;
          end
        end
        default: out_ready <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  always @(posedge clk) begin
    string msg;
    if (rst_n && out_valid && out_ready) begin
      msg = sb.check(out_data);
      if (msg != "") report(msg);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("pixel_to_ground_projection regression: fail");
      $finish;
    end
  end

  task automatic send_word(ptg_in_t px);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 20);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    in_valid <= 1'b1;
    in_data <= px;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note(px);
    burst_left--;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    burst_left = 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic program_regs(ptg_cfg_t c);
    logic [31:0] vals[6];
    vals[0] = 32'(c.image_rows);
    vals[1] = 32'(c.image_cols);
    vals[2] = c.tilt_tangent;
    vals[3] = c.pixel_over_focal;
    vals[4] = 32'(c.mount_height);
    vals[5] = c.mast_offset;
    for (int i = 0; i < 6; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= CFG_IDX_W'(i);
      cfg_data <= vals[i];
      @(posedge clk);
      sb.set_reg(CFG_IDX_W'(i), vals[i]);
    end
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic ptg_cfg_t random_setup(bit wild);
    ptg_cfg_t c;
    if (wild) begin
      c.image_rows = 13'($urandom);
      c.image_cols = 13'($urandom);
      c.tilt_tangent = $urandom;
      c.pixel_over_focal = $urandom;
      c.mount_height = 31'($urandom);
      c.mast_offset = $urandom;
    end else begin
      c.image_rows = 13'($urandom_range(1, 4096));
      c.image_cols = 13'($urandom_range(1, 4096));
      c.tilt_tangent = $urandom_range(0, 3) == 0 ? -$urandom_range(0, 1 << 23)
                                                 : $urandom_range(0, 1 << 25);
      c.pixel_over_focal = $urandom_range(1 << 18, 1 << 24);
      c.mount_height = 31'($urandom_range(0, 1 << 19));
      c.mast_offset = $signed($urandom_range(0, 1 << 19)) - (1 << 18);
    end
    return c;
  endfunction

  function automatic ptg_in_t random_pixel(ptg_cfg_t c);
    ptg_in_t px;
    if ($urandom_range(0, 4) != 0 && c.image_rows != 0 && c.image_cols != 0) begin
      px.pixel_row = 12'($urandom_range(0, (c.image_rows > 4096 ? 4096 : c.image_rows) - 1));
      px.pixel_col = 12'($urandom_range(0, (c.image_cols > 4096 ? 4096 : c.image_cols) - 1));
    end else begin
      px.pixel_row = 12'($urandom);
      px.pixel_col = 12'($urandom);
    end
    return px;
  endfunction

  initial begin
    ptg_cfg_t setups[3];
    ptg_in_t corners[8];
    ptg_cfg_t c;
    corners[0] = '{12'd0, 12'd0};
    corners[1] = '{12'd4095, 12'd4095};
    corners[2] = '{12'd239, 12'd319};
    corners[3] = '{12'd240, 12'd320};
    corners[4] = '{12'd479, 12'd639};
    corners[5] = '{12'd0, 12'd319};
    corners[6] = '{12'd0, 12'd639};
    corners[7] = '{12'd4095, 12'd0};
    // typical camera, then two sets at the register extremes
    setups[0] = '{13'd480, 13'd640, 32'sd5033165, 32'd7158278, 31'd65536, 32'sh8000};
    setups[1] = '{13'd0, 13'd8191, 32'sh8000_0000, 32'hFFFF_FFFF, 31'h7FFF_FFFF,
                  32'sh8000_0000};
    setups[2] = '{13'd4096, 13'd1, 32'sh7FFF_FFFF, 32'd0, 31'h7FFF_FFFF, 32'sh7FFF_FFFF};

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset defaults first, then each directed setup
    send_word(corners[1]);
    drain();
    for (int s = 0; s < 3; s++) begin
      program_regs(setups[s]);
      foreach (corners[i]) send_word(corners[i]);
      drain();
    end

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      c = random_setup(ph % 4 == 3);
      program_regs(c);
      for (int i = 0; i < PHASE_ITEMS; i++) send_word(random_pixel(c));
      drain();
    end

    if (errors == 0) begin
      $display("pixel_to_ground_projection regression: pass");
    end else begin
      $display("pixel_to_ground_projection regression: fail");
    end
    $finish;
  end

endmodule
